// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the base64url codec.
// Include this file by its bare name; it holds nothing but macro definitions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/b64u_pkg.sv -----
// Types, character constants and alphabet functions of the base64url codec.
// Used by the channel interfaces and by the engine, result queue and core modules.
package b64u_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_AW    = 2;
  localparam int unsigned RES_CW    = 3;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
    logic       err;
  } b64u_res_t;

  typedef struct packed {
    logic [1:0] cnt;
    b64u_res_t  r0;
    b64u_res_t  r1;
  } b64u_push_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] ve;
    ve = {2'b00, v};
    priority if (v < 6'd26) begin
      return CH_UP_A + ve;
    end else if (v < 6'd52) begin
      return CH_LO_A + ve - 8'd26;
    end else if (v < 6'd62) begin
      return CH_ZERO + ve - 8'd52;
    end else if (v == 6'd62) begin
      return CH_DASH;
    end else begin
      return CH_UNDER;
    end
  endfunction

  // Returns {ok, value}; ok is low for characters outside both alphabets.
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    priority if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - CH_UP_A;
      return {1'b1, t[5:0]};
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - CH_LO_A + 8'd26;
      return {1'b1, t[5:0]};
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO + 8'd52;
      return {1'b1, t[5:0]};
    end else if (c == CH_DASH || c == CH_PLUS) begin
      return {1'b1, 6'd62};
    end else if (c == CH_UNDER || c == CH_SLASH) begin
      return {1'b1, 6'd63};
    end else begin
      return {1'b0, t[5:0]};
    end
  endfunction

endpackage

// ----- rtl/b64u_in_if.sv -----
// Input channel of the base64url codec: handshake plus one input word.
// Depends on b64u_pkg for the byte width.
interface b64u_in_if;
  import b64u_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

// ----- rtl/b64u_out_if.sv -----
// Result channel of the base64url codec: handshake plus one result word.
// Depends on b64u_pkg for the byte width.
interface b64u_out_if;
  import b64u_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              out_valid;
  logic              out_last;
  logic              out_error;

  modport source (output valid, out_byte, out_valid, out_last, out_error, input ready);
  modport sink (input valid, out_byte, out_valid, out_last, out_error, output ready);
endinterface

// ----- rtl/b64u_engine.sv -----
// Codec step logic and stream state (bit store, bit count, discard flag, mode).
// Depends on b64u_pkg; produces up to two result words per accepted input word.
module b64u_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output b64u_pkg::b64u_push_t push
);
  import b64u_pkg::*;

  logic        mode_r;
  logic [11:0] store_r, store_nxt;
  logic [3:0]  held_r, held_nxt;
  logic        disc_r, disc_nxt;

  logic [2:0]  e_held;
  logic [11:0] e_val;
  logic [3:0]  e_bits;
  logic        e_two;
  logic [5:0]  e_ix0;
  logic [3:0]  e_rem;
  logic [11:0] e_store;
  logic [11:0] e_flush_w;
  logic        e_has_flush;

  logic        d_ok;
  logic [5:0]  d_v;
  logic [2:0]  d_held;
  logic [11:0] d_val;
  logic [3:0]  d_bits;
  logic        d_full;
  logic [3:0]  d_rem;
  logic [11:0] d_shift;
  logic [11:0] d_store;

  always_comb begin
    e_held      = (held_r > 4'd4) ? 3'd4 : held_r[2:0];
    e_val       = {store_r[3:0], in_byte};
    e_bits      = {1'b0, e_held} + 4'd8;
    e_two       = (e_bits >= 4'd12);
    e_ix0       = 6'(e_val >> (e_bits - 4'd6));
    e_rem       = e_two ? (e_bits - 4'd12) : (e_bits - 4'd6);
    e_store     = e_val & ((12'd1 << e_rem) - 12'd1);
    e_flush_w   = e_store << (4'd6 - e_rem);
    e_has_flush = in_last && (e_rem != 4'd0) && !e_two;
  end

  always_comb begin
    {d_ok, d_v} = dec_char(in_byte);
    d_held      = (held_r > 4'd6) ? 3'd6 : held_r[2:0];
    d_val       = {store_r[5:0], d_v};
    d_bits      = {1'b0, d_held} + 4'd6;
    d_full      = (d_bits >= 4'd8);
    d_rem       = d_full ? (d_bits - 4'd8) : d_bits;
    d_shift     = d_val >> d_rem;
    d_store     = d_val & ((12'd1 << d_rem) - 12'd1);
  end

  always_comb begin
    push      = '0;
    store_nxt = store_r;
    held_nxt  = held_r;
    disc_nxt  = disc_r;
    if (fire) begin
      if (mode_r == MODE_ENCODE) begin
        push.r0 = '{data: enc_char(e_ix0), dvalid: 1'b1, last: 1'b0, err: 1'b0};
        push.r1 = '{data: e_two ? enc_char(e_val[5:0]) : enc_char(e_flush_w[5:0]),
                    dvalid: 1'b1, last: in_last, err: 1'b0};
        if (e_two || e_has_flush) begin
          push.cnt = 2'd2;
        end else begin
          push.cnt     = 2'd1;
          push.r0.last = in_last;
        end
        store_nxt = in_last ? 12'd0 : e_store;
        held_nxt  = in_last ? 4'd0 : e_rem;
      end else if (disc_r) begin
        if (in_last) begin
          store_nxt = 12'd0;
          held_nxt  = 4'd0;
          disc_nxt  = 1'b0;
        end
      end else if (!d_ok) begin
        push.cnt  = 2'd1;
        push.r0   = '{data: 8'd0, dvalid: 1'b0, last: 1'b1, err: 1'b1};
        store_nxt = 12'd0;
        held_nxt  = 4'd0;
        disc_nxt  = !in_last;
      end else begin
        if (d_full) begin
          push.cnt = 2'd1;
          push.r0  = '{data: d_shift[7:0], dvalid: 1'b1, last: in_last, err: 1'b0};
        end else if (in_last) begin
          push.cnt = 2'd1;
          push.r0  = '{data: 8'd0, dvalid: 1'b0, last: 1'b1, err: 1'b0};
        end
        store_nxt = in_last ? 12'd0 : d_store;
        held_nxt  = in_last ? 4'd0 : d_rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ENCODE;
      store_r <= 12'd0;
      held_r  <= 4'd0;
      disc_r  <= 1'b0;
    end else if (cfg_we) begin
      mode_r  <= cfg_wdata;
      store_r <= 12'd0;
      held_r  <= 4'd0;
      disc_r  <= 1'b0;
    end else begin
      store_r <= store_nxt;
      held_r  <= held_nxt;
      disc_r  <= disc_nxt;
    end
  end

endmodule

// ----- rtl/b64u_rfifo.sv -----
// Result queue of the base64url codec: takes up to two words per cycle, gives one while head_ready is high.
// Depends on b64u_pkg for the result word type and the queue depth.
module b64u_rfifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64u_pkg::b64u_push_t push,
  output logic                 space,
  output logic                 head_valid,
  input  logic                 head_ready,
  output b64u_pkg::b64u_res_t  head
);
  import b64u_pkg::*;

  b64u_res_t         mem_r [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RES_CW-1:0] count_r, count_nxt;
  logic              pop;
  logic [RES_AW-1:0] wr_ptr_1;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign space      = (count_r <= RES_CW'(RES_DEPTH - 2));
  assign pop        = head_valid && head_ready;
  assign wr_ptr_1   = wr_ptr_r + 1'b1;
  assign count_nxt  = count_r + {1'b0, push.cnt} - {{(RES_CW-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RES_AW'(push.cnt);
      rd_ptr_r <= rd_ptr_r + RES_AW'(pop);
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/base64url_codec_core.sv -----
// Each result word is registered in the result queue before it is offered on the result channel.
// Input words are taken one per cycle while each yields at most one result and the
// one result channel keeps pace; bytes that encode to two characters can stall the input.
// A four-entry result queue takes new words while earlier results wait to be taken.
// Reset is synchronous and active low; it clears the mode to encode and empties all state.
module base64url_codec_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  b64u_in_if.sink         in_ch,
  b64u_out_if.source      out_ch
);
  import b64u_pkg::*;

  b64u_push_t push;
  b64u_res_t  head;
  logic       space;
  logic       fire;

  assign in_ch.ready = space;
  assign fire        = in_ch.valid && space;

  b64u_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .push      (push)
  );

  b64u_rfifo u_rfifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space      (space),
    .head_valid (out_ch.valid),
    .head_ready (out_ch.ready),
    .head       (head)
  );

  assign out_ch.out_byte  = head.data;
  assign out_ch.out_valid = head.dvalid;
  assign out_ch.out_last  = head.last;
  assign out_ch.out_error = head.err;

endmodule

// ----- rtl/b64u_checker.sv -----
// Port-level checks of the base64url codec, attached to the top level by bind.
// Depends on assert_macros.svh for the assertion forms.
`include "assert_macros.svh"

module b64u_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_hs_valid,
  input logic       out_hs_ready,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       out_last,
  input logic       out_error
);

  `ASSERT_SAME(a_marker_zero, clk, rst_n, out_hs_valid && !out_valid, out_byte == 8'd0, "marker word carries a nonzero byte")
  `ASSERT_SAME(a_error_form, clk, rst_n, out_hs_valid && out_error, out_last && !out_valid, "error word is not a bare final marker")
  `ASSERT_SAME(a_bare_end, clk, rst_n, out_hs_valid && !out_valid, out_last, "word without data is not final")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_hs_valid && !out_hs_ready, out_hs_valid && $stable({out_byte, out_valid, out_last, out_error}), "stalled result word changed")

endmodule

bind base64url_codec_core b64u_checker u_b64u_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_hs_valid (out_ch.valid),
  .out_hs_ready (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .out_valid    (out_ch.out_valid),
  .out_last     (out_ch.out_last),
  .out_error    (out_ch.out_error)
);
